// ----- hdl/mm3_pkg.sv -----
// Shared types, constants and helpers for the MurmurHash3 x64 128-bit engine.
package mm3_pkg;

    // Mixing constants
    localparam logic [63:0] C_ONE   = 64'h87c37b91114253d5;
    localparam logic [63:0] C_TWO   = 64'h4cf5ad432745937f;
    localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
    localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
    localparam logic [63:0] FMIX_A  = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_B  = 64'hc4ceb9fe1a85ec53;

    // Chunk geometry
    localparam logic [4:0] FULL_COUNT = 5'd16;
    localparam logic [4:0] HALF_COUNT = 5'd8;
    localparam int LEN_W = 31;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,      // capture chunk, start lanes and length
        OP_LOAD_K,    // k = masked word of the lane
        OP_MUL0,      // acc = k.lo * c.lo
        OP_MUL1,      // acc += (k.lo * c.hi) << 32
        OP_MUL2,      // k = acc + (k.hi * c.lo) << 32
        OP_ROT_K,     // k = rotl(k, 31 or 33)
        OP_XOR_H,     // h ^= k
        OP_ROT_ADD,   // h = rotl(h) + other lane
        OP_MUL5_ADD,  // h = h * 5 + lane constant
        OP_LEN_XOR,   // both lanes ^= length
        OP_ADD12,     // h1 += h2
        OP_ADD21,     // h2 += h1
        OP_K_FROM_H,  // k = h ^ (h >> 33)
        OP_XSHIFT,    // k ^= k >> 33
        OP_H_FROM_K,  // h = k ^ (k >> 33)
        OP_EMIT       // hash output register = lanes
    } t_dp_op;

    typedef enum logic {
        LANE_ONE,
        LANE_TWO
    } t_lane;

    typedef enum logic [1:0] {
        MC_C1,
        MC_C2,
        MC_FA,
        MC_FB
    } t_mconst;

    typedef struct packed {
        t_dp_op  op;
        t_lane   lane;
        t_mconst mconst;
        logic    start;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic last;
    } t_dp_stat;

    // Multiplier constant select
    function automatic logic [63:0] mul_const(input t_mconst sel);
        logic [63:0] c;
        case (sel)
            MC_C1:   c = C_ONE;
            MC_C2:   c = C_TWO;
            MC_FA:   c = FMIX_A;
            default: c = FMIX_B;
        endcase
        return c;
    endfunction

    // Mask keeping the low n bytes; n of eight or more keeps all
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < n) begin
                m[8*b +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

// ----- hdl/mm3_ifs.sv -----
// Request channel interfaces: input chunks and hash results.
interface mm3_chunk_if;
    logic        valid;
    logic        ready;
    logic [63:0] low_word;
    logic [63:0] high_word;
    logic [4:0]  byte_count;
    logic        last;

    modport source (output valid, low_word, high_word, byte_count, last, input ready);
    modport sink   (input valid, low_word, high_word, byte_count, last, output ready);
endinterface

interface mm3_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_a;
    logic [63:0] hash_b;

    modport source (output valid, hash_a, hash_b, input ready);
    modport sink   (input valid, hash_a, hash_b, output ready);
endinterface

// ----- hdl/mm3_datapath.sv -----
// Hash datapath: lane registers, shared 32x32 multiplier and mixing logic.
module mm3_datapath (
    input  logic               i_clk,
    input  mm3_pkg::t_dp_cmd   i_cmd,
    input  logic [31:0]        i_seed,
    input  logic [63:0]        i_low_word,
    input  logic [63:0]        i_high_word,
    input  logic [4:0]         i_byte_count,
    input  logic               i_last,
    output mm3_pkg::t_dp_stat  o_stat,
    output logic [63:0]        o_hash_a,
    output logic [63:0]        o_hash_b
);

    logic [63:0] r_w0, r_w1, n_w0, n_w1;
    logic        r_full, r_last, n_full, n_last;
    logic [63:0] r_h1, r_h2, n_h1, n_h2;
    logic [63:0] r_k, r_acc, n_k, n_acc;
    logic [mm3_pkg::LEN_W-1:0] r_len, n_len;
    logic [63:0] r_hash_a, r_hash_b, n_hash_a, n_hash_b;

    logic [4:0]  cnt_sat;
    logic        full_in;
    logic [63:0] mask0, mask1;
    logic [63:0] mconst;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic [63:0] h_sel, h_other, k_sx, h_sx, h_rot, k_rot, lane_add;

    // Count saturation and tail masks for the incoming chunk
    always_comb begin
        cnt_sat = (i_byte_count > mm3_pkg::FULL_COUNT) ? mm3_pkg::FULL_COUNT : i_byte_count;
        full_in = (cnt_sat == mm3_pkg::FULL_COUNT);
        mask0   = full_in ? '1 : mm3_pkg::byte_mask(cnt_sat[3:0]);
        if (full_in) begin
            mask1 = '1;
        end else if (cnt_sat > mm3_pkg::HALF_COUNT) begin
            mask1 = mm3_pkg::byte_mask(cnt_sat[3:0] - 4'd8);
        end else begin
            mask1 = '0;
        end
    end

    // Shared multiplier: one 32x32 partial product per cycle
    always_comb begin
        mconst = mm3_pkg::mul_const(i_cmd.mconst);
        case (i_cmd.op)
            mm3_pkg::OP_MUL0: begin
                mul_x = r_k[31:0];
                mul_y = mconst[31:0];
            end
            mm3_pkg::OP_MUL1: begin
                mul_x = r_k[31:0];
                mul_y = mconst[63:32];
            end
            default: begin
                mul_x = r_k[63:32];
                mul_y = mconst[31:0];
            end
        endcase
    end
    assign mul_p = 64'(mul_x) * 64'(mul_y);

    // Lane-selected operands
    always_comb begin
        h_sel    = (i_cmd.lane == mm3_pkg::LANE_TWO) ? r_h2 : r_h1;
        h_other  = (i_cmd.lane == mm3_pkg::LANE_TWO) ? r_h1 : r_h2;
        k_sx     = r_k ^ (r_k >> 33);
        h_sx     = h_sel ^ (h_sel >> 33);
        k_rot    = (i_cmd.lane == mm3_pkg::LANE_TWO) ? {r_k[30:0], r_k[63:31]}
                                                     : {r_k[32:0], r_k[63:33]};
        h_rot    = (i_cmd.lane == mm3_pkg::LANE_TWO) ? {h_sel[32:0], h_sel[63:33]}
                                                     : {h_sel[36:0], h_sel[63:37]};
        lane_add = (i_cmd.lane == mm3_pkg::LANE_TWO) ? mm3_pkg::ADD_TWO : mm3_pkg::ADD_ONE;
    end

    // Next-value logic per micro-operation
    always_comb begin
        logic [63:0] h_new;
        logic        h_wr;
        n_w0     = r_w0;
        n_w1     = r_w1;
        n_full   = r_full;
        n_last   = r_last;
        n_h1     = r_h1;
        n_h2     = r_h2;
        n_k      = r_k;
        n_acc    = r_acc;
        n_len    = r_len;
        n_hash_a = r_hash_a;
        n_hash_b = r_hash_b;
        h_new    = h_sel;
        h_wr     = 1'b0;
        case (i_cmd.op)
            mm3_pkg::OP_LOAD: begin
                n_w0   = i_low_word & mask0;
                n_w1   = i_high_word & mask1;
                n_full = full_in;
                n_last = i_last;
                if (i_cmd.start) begin
                    n_h1  = {32'd0, i_seed};
                    n_h2  = {32'd0, i_seed};
                    n_len = {{(mm3_pkg::LEN_W-5){1'b0}}, cnt_sat};
                end else begin
                    n_len = r_len + {{(mm3_pkg::LEN_W-5){1'b0}}, cnt_sat};
                end
            end
            mm3_pkg::OP_LOAD_K: begin
                n_k = (i_cmd.lane == mm3_pkg::LANE_TWO) ? r_w1 : r_w0;
            end
            mm3_pkg::OP_MUL0: begin
                n_acc = mul_p;
            end
            mm3_pkg::OP_MUL1: begin
                n_acc = r_acc + {mul_p[31:0], 32'd0};
            end
            mm3_pkg::OP_MUL2: begin
                n_k = r_acc + {mul_p[31:0], 32'd0};
            end
            mm3_pkg::OP_ROT_K: begin
                n_k = k_rot;
            end
            mm3_pkg::OP_XOR_H: begin
                h_new = h_sel ^ r_k;
                h_wr  = 1'b1;
            end
            mm3_pkg::OP_ROT_ADD: begin
                h_new = h_rot + h_other;
                h_wr  = 1'b1;
            end
            mm3_pkg::OP_MUL5_ADD: begin
                h_new = (h_sel << 2) + h_sel + lane_add;
                h_wr  = 1'b1;
            end
            mm3_pkg::OP_LEN_XOR: begin
                n_h1 = r_h1 ^ {33'd0, r_len};
                n_h2 = r_h2 ^ {33'd0, r_len};
            end
            mm3_pkg::OP_ADD12: begin
                n_h1 = r_h1 + r_h2;
            end
            mm3_pkg::OP_ADD21: begin
                n_h2 = r_h2 + r_h1;
            end
            mm3_pkg::OP_K_FROM_H: begin
                n_k = h_sx;
            end
            mm3_pkg::OP_XSHIFT: begin
                n_k = k_sx;
            end
            mm3_pkg::OP_H_FROM_K: begin
                h_new = k_sx;
                h_wr  = 1'b1;
            end
            mm3_pkg::OP_EMIT: begin
                n_hash_a = r_h1;
                n_hash_b = r_h2;
            end
            default: begin
            end
        endcase
        if (h_wr) begin
            if (i_cmd.lane == mm3_pkg::LANE_TWO) begin
                n_h2 = h_new;
            end else begin
                n_h1 = h_new;
            end
        end
    end

    // Datapath registers (payload only, no reset)
    always_ff @(posedge i_clk) begin
        r_w0     <= n_w0;
        r_w1     <= n_w1;
        r_full   <= n_full;
        r_last   <= n_last;
        r_h1     <= n_h1;
        r_h2     <= n_h2;
        r_k      <= n_k;
        r_acc    <= n_acc;
        r_len    <= n_len;
        r_hash_a <= n_hash_a;
        r_hash_b <= n_hash_b;
    end

    assign o_stat.full = r_full;
    assign o_stat.last = r_last;
    assign o_hash_a    = r_hash_a;
    assign o_hash_b    = r_hash_b;

endmodule

// ----- hdl/mm3_controller.sv -----
// Hash sequencer: steps the datapath through body, tail and finalization.
module mm3_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  mm3_pkg::t_dp_stat  i_stat,
    output mm3_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MIX1  = 10'b00_0000_0010,
        S_BODY1 = 10'b00_0000_0100,
        S_MIX2  = 10'b00_0000_1000,
        S_BODY2 = 10'b00_0001_0000,
        S_FIN_A = 10'b00_0010_0000,
        S_FMIX1 = 10'b00_0100_0000,
        S_FMIX2 = 10'b00_1000_0000,
        S_FIN_B = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    localparam logic [3:0] STEP_MIX_LAST  = 4'd8;
    localparam logic [3:0] STEP_BODY_LAST = 4'd1;
    localparam logic [3:0] STEP_FINA_LAST = 4'd2;
    localparam logic [3:0] STEP_FINB_LAST = 4'd1;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_in_msg, n_in_msg;
    logic       r_out_valid, n_out_valid;

    // Step decode shared by the lane mix and fmix sequences
    function automatic mm3_pkg::t_dp_op seq_op(input logic [3:0] step,
                                               input mm3_pkg::t_dp_op first_op,
                                               input mm3_pkg::t_dp_op mid_op,
                                               input mm3_pkg::t_dp_op last_op);
        mm3_pkg::t_dp_op op;
        case (step) inside
            4'd0:       op = first_op;
            4'd1, 4'd5: op = mm3_pkg::OP_MUL0;
            4'd2, 4'd6: op = mm3_pkg::OP_MUL1;
            4'd3, 4'd7: op = mm3_pkg::OP_MUL2;
            4'd4:       op = mid_op;
            default:    op = last_op;
        endcase
        return op;
    endfunction

    always_comb begin
        logic done;
        n_state     = r_state;
        n_step      = r_step + 4'd1;
        n_in_msg    = r_in_msg;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd.op     = mm3_pkg::OP_NONE;
        o_cmd.lane   = mm3_pkg::LANE_ONE;
        o_cmd.mconst = mm3_pkg::MC_C1;
        o_cmd.start  = 1'b0;
        done         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    o_cmd.op    = mm3_pkg::OP_LOAD;
                    o_cmd.start = ~r_in_msg;
                    n_in_msg    = 1'b1;
                    n_state     = S_MIX1;
                end
            end
            // lane one: k1 * C1, rotl 31, * C2
            S_MIX1: begin
                o_cmd.op     = seq_op(r_step, mm3_pkg::OP_LOAD_K, mm3_pkg::OP_ROT_K,
                                      mm3_pkg::OP_XOR_H);
                o_cmd.mconst = (r_step < 4'd4) ? mm3_pkg::MC_C1 : mm3_pkg::MC_C2;
                done         = (r_step == STEP_MIX_LAST);
                if (done) begin
                    n_state = i_stat.full ? S_BODY1 : S_MIX2;
                end
            end
            S_BODY1: begin
                o_cmd.op = (r_step == 4'd0) ? mm3_pkg::OP_ROT_ADD : mm3_pkg::OP_MUL5_ADD;
                done     = (r_step == STEP_BODY_LAST);
                if (done) begin
                    n_state = S_MIX2;
                end
            end
            // lane two: k2 * C2, rotl 33, * C1
            S_MIX2: begin
                o_cmd.lane   = mm3_pkg::LANE_TWO;
                o_cmd.op     = seq_op(r_step, mm3_pkg::OP_LOAD_K, mm3_pkg::OP_ROT_K,
                                      mm3_pkg::OP_XOR_H);
                o_cmd.mconst = (r_step < 4'd4) ? mm3_pkg::MC_C2 : mm3_pkg::MC_C1;
                done         = (r_step == STEP_MIX_LAST);
                if (done) begin
                    n_state = i_stat.full ? S_BODY2 : S_FIN_A;
                end
            end
            S_BODY2: begin
                o_cmd.lane = mm3_pkg::LANE_TWO;
                o_cmd.op   = (r_step == 4'd0) ? mm3_pkg::OP_ROT_ADD : mm3_pkg::OP_MUL5_ADD;
                done       = (r_step == STEP_BODY_LAST);
                if (done) begin
                    n_state = i_stat.last ? S_FIN_A : S_IDLE;
                end
            end
            // length fold, then the first cross-adds h1 += h2 and h2 += h1
            S_FIN_A: begin
                case (r_step)
                    4'd0:    o_cmd.op = mm3_pkg::OP_LEN_XOR;
                    4'd1:    o_cmd.op = mm3_pkg::OP_ADD12;
                    default: o_cmd.op = mm3_pkg::OP_ADD21;
                endcase
                done = (r_step == STEP_FINA_LAST);
                if (done) begin
                    n_state = S_FMIX1;
                end
            end
            S_FMIX1, S_FMIX2: begin
                o_cmd.lane   = (r_state == S_FMIX2) ? mm3_pkg::LANE_TWO : mm3_pkg::LANE_ONE;
                o_cmd.op     = seq_op(r_step, mm3_pkg::OP_K_FROM_H, mm3_pkg::OP_XSHIFT,
                                      mm3_pkg::OP_H_FROM_K);
                o_cmd.mconst = (r_step < 4'd4) ? mm3_pkg::MC_FA : mm3_pkg::MC_FB;
                done         = (r_step == STEP_MIX_LAST);
                if (done) begin
                    n_state = (r_state == S_FMIX2) ? S_FIN_B : S_FMIX2;
                end
            end
            S_FIN_B: begin
                o_cmd.op = (r_step == 4'd0) ? mm3_pkg::OP_ADD12 : mm3_pkg::OP_ADD21;
                done     = (r_step == STEP_FINB_LAST);
                if (done) begin
                    n_state = S_EMIT;
                end
            end
            // wait for the output register to free up
            S_EMIT: begin
                n_step = '0;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = mm3_pkg::OP_EMIT;
                    n_out_valid = 1'b1;
                    n_in_msg    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase

        if (done) begin
            n_step = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_in_msg    <= n_in_msg;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/murmur3_x64_128_hash_top.sv -----
// Top level of the MurmurHash3 x64 128-bit engine with its seed register port.
//
// Messages stream in as 16-byte chunks; a chunk with fewer than 16 bytes, or
// one with last set, ends the message and produces one 128-bit hash. All
// 64-bit products go through a single 32x32 multiplier as three partial
// products. Each chunk is accepted, then mixed into lane one and lane two,
// with a body update of each lane after its mix for a full chunk; a chunk
// that ends the message then runs the finalization before the emit. The
// result sits in an output register; a new chunk is taken once the previous
// one is done, while the result may still wait. The seed register is sampled
// at the first chunk of each message; writing it mid-message affects the next.
module murmur3_x64_128_hash_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mm3_chunk_if.sink         i_chunk,
    mm3_hash_if.source        o_hash,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0]        r_seed;
    logic               seed_sel;
    mm3_pkg::t_dp_cmd   cmd;
    mm3_pkg::t_dp_stat  stat;

    // Seed register at byte addresses zero to three (paddr[2] low)
    assign seed_sel = (paddr[2] == 1'b0);
    assign pready   = 1'b1;
    assign prdata   = seed_sel ? r_seed : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && seed_sel) begin
            r_seed <= pwdata;
        end
    end

    mm3_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_chunk.valid),
        .o_in_ready  (i_chunk.ready),
        .i_out_ready (o_hash.ready),
        .o_out_valid (o_hash.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mm3_datapath u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_seed       (r_seed),
        .i_low_word   (i_chunk.low_word),
        .i_high_word  (i_chunk.high_word),
        .i_byte_count (i_chunk.byte_count),
        .i_last       (i_chunk.last),
        .o_stat       (stat),
        .o_hash_a     (o_hash.hash_a),
        .o_hash_b     (o_hash.hash_b)
    );

endmodule

// ----- tb/murmur3_x64_128_hash_top_test.sv -----
// Self-checking testbench for the MurmurHash3 x64 128-bit hash engine top level.
`timescale 1ns / 1ps

module murmur3_x64_128_hash_top_test;

    // Hash constants, kept locally so the predictor is independent of the design
    localparam logic [63:0] K_MUL_ONE = 64'h87c37b91114253d5;
    localparam logic [63:0] K_MUL_TWO = 64'h4cf5ad432745937f;
    localparam logic [63:0] K_ADD_ONE = 64'h0000000052dce729;
    localparam logic [63:0] K_ADD_TWO = 64'h0000000038495ab5;
    localparam logic [63:0] K_FMIX_A  = 64'hff51afd7ed558ccd;
    localparam logic [63:0] K_FMIX_B  = 64'hc4ceb9fe1a85ec53;

    localparam logic [2:0] SEED_ADDR      = 3'd0;
    localparam int         RESET_CYCLES   = 12;
    localparam int         DRAIN_CYCLES   = 64;    // beyond the slowest chunk
    localparam int         PHASE_ITEMS    = 150;
    localparam int         NUM_PHASES     = 6;
    localparam int         LONG_HOLD      = 500;
    localparam int         HOLD_AFTER     = 40;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         MAX_PRINTS     = 40;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } t_idle_mode;

    typedef struct packed {
        logic [63:0] low_word;
        logic [63:0] high_word;
        logic [4:0]  byte_count;
        logic        last;
    } t_chunk;

    typedef struct packed {
        logic [63:0] hash_a;
        logic [63:0] hash_b;
    } t_hash;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mm3_chunk_if chunk_bus();
    mm3_hash_if  hash_bus();

    murmur3_x64_128_hash_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chunk (chunk_bus),
        .o_hash  (hash_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Request queues and counters
    t_chunk     pending_chunks[$];
    t_hash      expected_hashes[$];
    int         error_count     = 0;
    int         chunks_accepted = 0;
    int         hashes_checked  = 0;
    int         seeds_written   = 0;
    int         quiet_cycles    = 0;
    int         tx_gap          = 0;
    int         rx_gap          = 0;
    int         hold_left       = 0;
    bit         hold_done       = 1'b0;
    t_idle_mode tx_mode         = IDLE_LIGHT;
    t_idle_mode rx_mode         = IDLE_LIGHT;

    // Shadow state of the hash engine
    logic [31:0] seed_shadow = '0;
    logic [63:0] lane_a      = '0;
    logic [63:0] lane_b      = '0;
    logic [30:0] msg_len     = '0;
    bit          msg_open    = 1'b0;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s got %h expected %h", $realtime, what, got, want);
        end
    endtask

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function automatic logic [63:0] scramble_low(input logic [63:0] k);
        k = k * K_MUL_ONE;
        k = rotl64(k, 31);
        return k * K_MUL_TWO;
    endfunction

    function automatic logic [63:0] scramble_high(input logic [63:0] k);
        k = k * K_MUL_TWO;
        k = rotl64(k, 33);
        return k * K_MUL_ONE;
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] k);
        k = k ^ (k >> 33);
        k = k * K_FMIX_A;
        k = k ^ (k >> 33);
        k = k * K_FMIX_B;
        return k ^ (k >> 33);
    endfunction

    function automatic logic [63:0] keep_bytes(input int n);
        if (n >= 8) begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Advance the shadow lanes by one chunk; returns 1 when a hash comes out
    function automatic bit hash_chunk(input t_chunk c, output t_hash h);
        logic [63:0] a;
        logic [63:0] b;
        int          n;
        h = '0;
        n = (c.byte_count > 5'd16) ? 16 : int'(c.byte_count);
        if (!msg_open) begin
            lane_a   = {32'b0, seed_shadow};
            lane_b   = {32'b0, seed_shadow};
            msg_len  = '0;
            msg_open = 1'b1;
        end
        a = lane_a;
        b = lane_b;
        if (n == 16) begin
            a = a ^ scramble_low(c.low_word);
            a = rotl64(a, 27) + b;
            a = a * 64'd5 + K_ADD_ONE;
            b = b ^ scramble_high(c.high_word);
            b = rotl64(b, 31) + a;
            b = b * 64'd5 + K_ADD_TWO;
            lane_a  = a;
            lane_b  = b;
            msg_len = msg_len + 31'd16;
            if (!c.last) begin
                return 1'b0;
            end
        end else begin
            if (n > 8) begin
                b = b ^ scramble_high(c.high_word & keep_bytes(n - 8));
            end
            if (n > 0) begin
                a = a ^ scramble_low(c.low_word & keep_bytes(n));
            end
            msg_len = msg_len + 31'(n);
        end
        // Finalization: length fold, cross adds and avalanche of both lanes
        a = a ^ {33'b0, msg_len};
        b = b ^ {33'b0, msg_len};
        a = a + b;
        b = b + a;
        a = avalanche(a);
        b = avalanche(b);
        a = a + b;
        b = b + a;
        h.hash_a = a;
        h.hash_b = b;
        lane_a   = a;
        lane_b   = b;
        msg_open = 1'b0;
        return 1'b1;
    endfunction

    // Idle length: mostly back to back or short, now and then a long gap
    function automatic int pick_gap(input t_idle_mode mode);
        int r;
        if (mode == IDLE_NONE) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < ((mode == IDLE_HEAVY) ? 40 : 70)) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_chunk make_chunk(input int n, input bit is_last);
        t_chunk c;
        c.low_word   = {$urandom, $urandom};
        c.high_word  = {$urandom, $urandom};
        c.byte_count = 5'(n);
        c.last       = is_last;
        return c;
    endfunction

    function automatic void add_chunk(input logic [63:0] lo, input logic [63:0] hi,
                                      input int n, input bit is_last);
        t_chunk c;
        c.low_word   = lo;
        c.high_word  = hi;
        c.byte_count = 5'(n);
        c.last       = is_last;
        pending_chunks.push_back(c);
    endfunction

    // One well-formed message with random content; returns its chunk count
    function automatic int queue_message();
        int nfull;
        int roll;
        nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
        for (int i = 0; i < nfull; i++) begin
            pending_chunks.push_back(make_chunk(($urandom_range(0, 9) == 0) ?
                                     $urandom_range(17, 31) : 16, 1'b0));
        end
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            pending_chunks.push_back(make_chunk($urandom_range(1, 15), $urandom_range(0, 4) != 0));
        end else if (roll < 9) begin
            pending_chunks.push_back(make_chunk(($urandom_range(0, 3) == 0) ?
                                     $urandom_range(17, 31) : 16, 1'b1));
        end else begin
            pending_chunks.push_back(make_chunk(0, 1'($urandom_range(0, 1))));
        end
        return nfull + 1;
    endfunction

    // Random phase: mostly messages, some stray chunks of any count
    function automatic void queue_random_phase(input int budget);
        int made;
        made = 0;
        while (made < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                pending_chunks.push_back(make_chunk($urandom_range(0, 31),
                                                    1'($urandom_range(0, 1))));
                made++;
            end else begin
                made += queue_message();
            end
        end
    endfunction

    task automatic wait_drained();
        while (pending_chunks.size() != 0 || chunk_bus.valid || expected_hashes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Config request: setup cycle, then access cycle until pready
    task automatic cfg_access(input bit is_write, input logic [2:0] addr,
                              input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (is_write && addr == SEED_ADDR) begin
            seed_shadow = data;
            seeds_written++;
        end
    endtask

    // Stimulus
    initial begin : stimulus
        logic [31:0] seed_val;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        chunk_bus.valid      = 1'b0;
        chunk_bus.low_word   = '0;
        chunk_bus.high_word  = '0;
        chunk_bus.byte_count = '0;
        chunk_bus.last       = 1'b0;
        hash_bus.ready       = 1'b0;

        // Directed chunks, run under the reset seed
        add_chunk('1, '1, 0, 1'b1);                          // empty message
        add_chunk('1, '1, 0, 1'b0);                          // zero count ends it too
        add_chunk('1, '1, 1, 1'b1);
        add_chunk(64'h0123456789abcdef, '1, 7, 1'b1);
        add_chunk(64'hfedcba9876543210, '1, 8, 1'b1);
        add_chunk('1, 64'h00000000000000ff, 9, 1'b1);
        add_chunk('1, '1, 15, 1'b1);
        add_chunk('1, '1, 15, 1'b0);                         // short chunk without last
        add_chunk('0, '0, 16, 1'b1);                         // full chunk with last
        add_chunk('1, '1, 16, 1'b1);
        add_chunk(64'h8000000000000001, 64'h7ffffffffffffffe, 16, 1'b0);
        add_chunk(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5, 1'b1);
        add_chunk('1, '1, 31, 1'b1);                         // count saturates to 16
        add_chunk(64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 17, 1'b0);
        add_chunk('1, '1, 0, 1'b1);
        add_chunk('0, '1, 16, 1'b0);
        add_chunk('1, '0, 16, 1'b0);
        add_chunk('1, '1, 16, 1'b1);
        add_chunk(64'h00000000000000aa, '0, 1, 1'b0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                case (ph)
                    1:       seed_val = 32'hffffffff;
                    3:       seed_val = 32'h80000000;
                    5:       seed_val = 32'h00000000;
                    default: seed_val = $urandom;
                endcase
                cfg_access(1'b1, SEED_ADDR, seed_val);
                cfg_access(1'b0, SEED_ADDR, '0);
            end
            tx_mode = (ph == 1) ? IDLE_NONE : ((ph == 3) ? IDLE_HEAVY : IDLE_LIGHT);
            rx_mode = (ph == 1) ? IDLE_NONE : ((ph == 4) ? IDLE_HEAVY : IDLE_LIGHT);
            queue_random_phase(PHASE_ITEMS);
            // leave a message open so the next seed write lands mid-message
            if (ph % 2 == 0) begin
                pending_chunks.push_back(make_chunk(16, 1'b0));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_hashes.size() != 0) begin
            report_mismatch("hashes never delivered", 64'(expected_hashes.size()), 64'd0);
        end
        $display("Covered %0d chunks and %0d hashes under %0d seed writes,",
                 chunks_accepted, hashes_checked, seeds_written);
        $display("with directed edge counts, random idling and a long output stall.");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Chunk driver: predicts each accepted request, then offers the next
    always @(posedge i_clk) begin : chunk_driver
        t_chunk seen;
        t_chunk nxt;
        t_hash  want;
        if (!i_rst_n) begin
            chunk_bus.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (chunk_bus.valid && chunk_bus.ready) begin
                chunks_accepted++;
                seen.low_word   = chunk_bus.low_word;
                seen.high_word  = chunk_bus.high_word;
                seen.byte_count = chunk_bus.byte_count;
                seen.last       = chunk_bus.last;
                if (hash_chunk(seen, want)) begin
                    expected_hashes.push_back(want);
                end
            end
            if (!chunk_bus.valid || chunk_bus.ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    chunk_bus.valid <= 1'b0;
                end else if (pending_chunks.size() != 0) begin
                    nxt = pending_chunks.pop_front();
                    chunk_bus.low_word   <= nxt.low_word;
                    chunk_bus.high_word  <= nxt.high_word;
                    chunk_bus.byte_count <= nxt.byte_count;
                    chunk_bus.last       <= nxt.last;
                    chunk_bus.valid      <= 1'b1;
                    tx_gap = pick_gap(tx_mode);
                end else begin
                    chunk_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Hash monitor: checks results in order and throttles ready
    always @(posedge i_clk) begin : hash_monitor
        t_hash want;
        if (!i_rst_n) begin
            hash_bus.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (hash_bus.valid && hash_bus.ready) begin
                hashes_checked++;
                if (expected_hashes.size() == 0) begin
                    report_mismatch("hash with no message pending", hash_bus.hash_a, 64'd0);
                end else begin
                    want = expected_hashes.pop_front();
                    if (hash_bus.hash_a !== want.hash_a) begin
                        report_mismatch("hash_a", hash_bus.hash_a, want.hash_a);
                    end
                    if (hash_bus.hash_b !== want.hash_b) begin
                        report_mismatch("hash_b", hash_bus.hash_b, want.hash_b);
                    end
                end
            end
            // one long hold-off so the engine backs up into its input
            if (hold_left != 0) begin
                hold_left--;
                hash_bus.ready <= 1'b0;
            end else if (!hold_done && hashes_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                hash_bus.ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                hash_bus.ready <= 1'b0;
            end else begin
                hash_bus.ready <= 1'b1;
                if (hash_bus.valid && hash_bus.ready) begin
                    rx_gap = pick_gap(rx_mode);
                end
            end
        end
    end

    // Seed readback check on config reads
    always @(posedge i_clk) begin
        if (i_rst_n && psel && penable && !pwrite && pready) begin
            if (prdata !== seed_shadow) begin
                report_mismatch("seed readback", 64'(prdata), 64'(seed_shadow));
            end
        end
    end

    // Watchdog on cycles with no accepted request on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (chunk_bus.valid && chunk_bus.ready) ||
            (hash_bus.valid && hash_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout after %0d idle cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
hdl/mm3_pkg.sv
hdl/mm3_ifs.sv
hdl/mm3_datapath.sv
hdl/mm3_controller.sv
hdl/murmur3_x64_128_hash_top.sv
tb/murmur3_x64_128_hash_top_test.sv
